// File: rtl/tvs_pkg.sv
// Shared types and constants for the texture-seam vertex splitter.
`default_nettype none

package tvs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int STEP_W      = ADDR_W + 1;
    localparam int COORD_W     = 48;

    // Register indexes on the configuration channel
    localparam logic [1:0] CFG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] CFG_TABLE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE    = 2'd2;

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_CORNER = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef struct packed {
        logic [10:0] vertex_count;
        logic [10:0] table_limit;
        logic [15:0] tolerance;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic [9:0]         vertex_index;
        logic signed [23:0] tex_u;
        logic signed [23:0] tex_v;
        logic               textured;
    } t_item;

    typedef struct packed {
        logic [9:0]  out_index;
        logic [9:0]  origin_index;
        logic        allocated;
        logic        failed;
        logic [10:0] slot_count;
    } t_res;

    // Per-slot bookkeeping: in use, has successor, successor slot
    typedef struct packed {
        logic              used;
        logic              link_valid;
        logic [ADDR_W-1:0] link;
    } t_meta;

    localparam int META_W = $bits(t_meta);

endpackage

`default_nettype wire

// File: rtl/tvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tvs_cmp.sv
// Shared coordinate compare unit: one axis per use, |a - b| < tolerance.
`default_nettype none

module tvs_cmp (
    input  wire logic               i_clk,
    input  wire logic               i_load,
    input  wire logic signed [23:0] i_a,
    input  wire logic signed [23:0] i_b,
    input  wire logic [15:0]        i_tol,
    output logic                    o_ok
);

    logic signed [24:0] r_diff;
    logic signed [24:0] n_diff;
    logic        [24:0] mag;

    assign n_diff = 25'(i_a) - 25'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_diff <= n_diff;
        end
    end

    // magnitude is at most 2^24, fits unsigned in 25 bits
    assign mag  = r_diff[24] ? 25'(-r_diff) : 25'(r_diff);
    assign o_ok = mag < {9'd0, i_tol};

endmodule

`default_nettype wire

// File: rtl/tvs_ctrl.sv
// Sequencer: table clearing, duplicate-chain walk and slot allocation.
`default_nettype none

module tvs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tvs_pkg::t_cfg  i_cfg,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire tvs_pkg::t_item i_item,
    input  wire logic          i_out_free,
    output logic               o_done,
    output tvs_pkg::t_res      o_res
);

    import tvs_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_ISSUE = 8'b0000_0100,
        S_READ  = 8'b0000_1000,
        S_DIFFV = 8'b0001_0000,
        S_TEST  = 8'b0010_0000,
        S_ALLOC = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_cnt, n_cnt;
    logic               r_rst_clr, n_rst_clr;
    logic [10:0]        r_fp, n_fp;
    logic               r_fail, n_fail;
    logic [ADDR_W-1:0]  r_cur, n_cur;
    logic [STEP_W-1:0]  r_steps, n_steps;
    logic signed [23:0] r_u, n_u;
    logic signed [23:0] r_v, n_v;
    t_op                r_op, n_op;
    logic [9:0]         r_res_index, n_res_index;
    logic [9:0]         r_res_origin, n_res_origin;
    logic               r_res_alloc, n_res_alloc;
    logic               r_match_u, n_match_u;

    // memory ports
    logic               meta_we, meta_re, coord_we, coord_re;
    logic [ADDR_W-1:0]  meta_waddr, coord_waddr;
    t_meta              meta_wdata, meta_rd;
    logic [META_W-1:0]  meta_rdata;
    logic [COORD_W-1:0] coord_wdata, coord_rdata;

    // compare unit
    logic               cmp_load, cmp_ok;
    logic signed [23:0] cmp_a, cmp_b;

    logic               match, overflow, in_range;

    assign meta_rd = t_meta'(meta_rdata);

    tvs_ram #(.WIDTH(META_W), .DEPTH(TABLE_DEPTH)) u_meta_ram (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_re    (meta_re),
        .i_raddr (r_cur),
        .o_rdata (meta_rdata)
    );

    tvs_ram #(.WIDTH(COORD_W), .DEPTH(TABLE_DEPTH)) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (coord_we),
        .i_waddr (coord_waddr),
        .i_wdata (coord_wdata),
        .i_re    (coord_re),
        .i_raddr (r_cur),
        .o_rdata (coord_rdata)
    );

    tvs_cmp u_cmp (
        .i_clk  (i_clk),
        .i_load (cmp_load),
        .i_a    (cmp_a),
        .i_b    (cmp_b),
        .i_tol  (i_cfg.tolerance),
        .o_ok   (cmp_ok)
    );

    assign match    = r_match_u && cmp_ok;
    assign overflow = (r_fp >= i_cfg.table_limit) || (32'(r_fp) >= TABLE_DEPTH);
    assign in_range = 32'(i_item.vertex_index) < TABLE_DEPTH;

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = (r_state == S_DONE) && i_out_free;

    always_comb begin
        o_res.out_index    = r_res_index;
        o_res.origin_index = r_res_origin;
        o_res.allocated    = r_res_alloc;
        o_res.failed       = r_fail;
        o_res.slot_count   = (r_op == OP_FINISH && !r_fail) ? r_fp : 11'd0;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_rst_clr    = r_rst_clr;
        n_fp         = r_fp;
        n_fail       = r_fail;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_u          = r_u;
        n_v          = r_v;
        n_op         = r_op;
        n_res_index  = r_res_index;
        n_res_origin = r_res_origin;
        n_res_alloc  = r_res_alloc;
        n_match_u    = r_match_u;

        meta_we     = 1'b0;
        meta_re     = 1'b0;
        meta_waddr  = r_cur;
        meta_wdata  = '0;
        coord_we    = 1'b0;
        coord_re    = 1'b0;
        coord_waddr = r_cur;
        coord_wdata = {r_v, r_u};
        cmp_load    = 1'b0;
        cmp_a       = coord_rdata[23:0];
        cmp_b       = r_u;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op         = i_item.op;
                    n_u          = i_item.tex_u;
                    n_v          = i_item.tex_v;
                    n_res_index  = '0;
                    n_res_origin = '0;
                    n_res_alloc  = 1'b0;
                    n_state      = S_DONE;
                    unique case (i_item.op)
                        OP_BEGIN: begin
                            n_cnt     = '0;
                            n_rst_clr = 1'b0;
                            n_state   = S_CLEAR;
                        end
                        OP_CORNER: begin
                            n_res_index  = i_item.vertex_index;
                            n_res_origin = i_item.vertex_index;
                            if (i_item.textured && !r_fail && in_range) begin
                                n_cur   = ADDR_W'(i_item.vertex_index);
                                n_steps = STEP_W'(1);
                                n_state = S_ISSUE;
                            end
                        end
                        OP_FINISH, OP_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_cnt;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == ADDR_W'(TABLE_DEPTH - 1)) begin
                    if (r_rst_clr) begin
                        n_rst_clr = 1'b0;
                        n_state   = S_IDLE;
                    end else begin
                        n_fp    = i_cfg.vertex_count;
                        n_fail  = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end
            S_ISSUE: begin
                meta_re  = 1'b1;
                coord_re = 1'b1;
                n_state  = S_READ;
            end
            S_READ: begin
                if (r_steps == STEP_W'(1) && !meta_rd.used) begin
                    // first textured use of this vertex: store its coordinate
                    meta_we    = 1'b1;
                    meta_wdata = '{used: 1'b1, link_valid: meta_rd.link_valid,
                                   link: meta_rd.link};
                    coord_we   = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    cmp_load = 1'b1;
                    n_state  = S_DIFFV;
                end
            end
            S_DIFFV: begin
                cmp_load  = 1'b1;
                cmp_a     = coord_rdata[47:24];
                cmp_b     = r_v;
                n_match_u = cmp_ok;
                n_state   = S_TEST;
            end
            S_TEST: begin
                if (match) begin
                    n_res_index = 10'(r_cur);
                    n_state     = S_DONE;
                end else if (meta_rd.link_valid && 32'(r_steps) < TABLE_DEPTH) begin
                    n_cur   = meta_rd.link;
                    n_steps = r_steps + 1'b1;
                    n_state = S_ISSUE;
                end else if (overflow) begin
                    n_fail  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    // hook the new slot onto the chain tail
                    meta_we    = 1'b1;
                    meta_wdata = '{used: meta_rd.used, link_valid: 1'b1,
                                   link: ADDR_W'(r_fp)};
                    n_state    = S_ALLOC;
                end
            end
            S_ALLOC: begin
                meta_we     = 1'b1;
                meta_waddr  = ADDR_W'(r_fp);
                meta_wdata  = '{used: 1'b1, link_valid: 1'b0, link: '0};
                coord_we    = 1'b1;
                coord_waddr = ADDR_W'(r_fp);
                n_fp        = r_fp + 11'd1;
                n_res_index = 10'(r_fp);
                n_res_alloc = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_rst_clr <= 1'b1;
            r_fp      <= '0;
            r_fail    <= 1'b0;
            r_op      <= OP_NONE;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_rst_clr <= n_rst_clr;
            r_fp      <= n_fp;
            r_fail    <= n_fail;
            r_op      <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_steps      <= n_steps;
        r_u          <= n_u;
        r_v          <= n_v;
        r_res_index  <= n_res_index;
        r_res_origin <= n_res_origin;
        r_res_alloc  <= n_res_alloc;
        r_match_u    <= n_match_u;
    end

endmodule

`default_nettype wire

// File: rtl/texcoord_vertex_splitter_top.sv
// Top level: stream ports, configuration registers and result register.
//
// Splits mesh vertices along texture seams. Each slave-side transaction is
// one op: begin (clear table), corner (vertex index plus u/v), or finish.
// Every op yields exactly one master-side transaction.
// Configuration: write channel i_cfg_valid/o_cfg_ready with i_cfg_index
// (0 vertex_count, 1 table_limit, 2 tolerance) and i_cfg_data; always
// ready, write only while the block is idle.
// Outcome of each op:
//   pass-through corner, finish, unused op: no table access
//   first use of a vertex: coordinate stored in its own slot
//   corner matching at chain node n (head n=1): that node's slot reported
//   corner needing a new slot after n nodes: slot appended, or failure on overflow
//   begin: 1024-entry clearing pass
// One op is in the sequencer at a time, each slot visit costing a RAM
// read plus two passes through the shared compare unit; o_s_tready
// returns as the result is loaded into the output register.
// After reset the same 1024-entry clearing pass runs with o_s_tready low.
// A stalled receiver holds the result in the output register; the next op
// is still accepted, and its result waits in the sequencer.
`default_nettype none

module texcoord_vertex_splitter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    // slave side
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,  // vertex_index[9:0], tex_u[33:10], tex_v[57:34]
    input  wire logic [2:0]  i_s_tuser,  // op[1:0], textured[2]
    // master side
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [31:0]      o_m_tdata,  // out_index[9:0], origin_index[19:10], slot_count[30:20]
    output logic [1:0]       o_m_tuser   // allocated[0], failed[1]
);

    import tvs_pkg::*;

    t_cfg  r_cfg;
    t_item item;
    t_res  res;
    t_res  r_out;
    logic  r_out_valid;
    logic  out_free, done, ready;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vertex_count <= 11'd0;
            r_cfg.table_limit  <= 11'd1024;
            r_cfg.tolerance    <= 16'd66;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VERTEX_COUNT: r_cfg.vertex_count <= i_cfg_data[10:0];
                CFG_TABLE_LIMIT:  r_cfg.table_limit  <= i_cfg_data[10:0];
                CFG_TOLERANCE:    r_cfg.tolerance    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        item.op           = t_op'(i_s_tuser[1:0]);
        item.vertex_index = i_s_tdata[9:0];
        item.tex_u        = i_s_tdata[33:10];
        item.tex_v        = i_s_tdata[57:34];
        item.textured     = i_s_tuser[2];
    end

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = ready;

    tvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_s_tvalid),
        .o_ready    (ready),
        .i_item     (item),
        .i_out_free (out_free),
        .o_done     (done),
        .o_res      (res)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out.slot_count, r_out.origin_index, r_out.out_index};
    assign o_m_tuser  = {r_out.failed, r_out.allocated};

    // one op in flight: no new transaction the cycle after one is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second transaction accepted while busy");

    // a new slot is never reported together with a failure
    a_alloc_not_failed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> !o_m_tuser[1])
        else $error("allocation reported with failure set");

    // a slot count comes only with a finish result
    a_count_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[30:20] != 11'd0) |->
            (o_m_tdata[19:0] == 20'd0 && !o_m_tuser[0] && !o_m_tuser[1]))
        else $error("slot count mixed with corner result");

    // result register only refills when free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_out)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
